@@ rtl/bmf_pkg.sv @@
package bmf_pkg;

  // Defaults for the top level parameters
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_WINDOW_DEF = 9;

  localparam int PIX_W = 8;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;

  localparam logic [CFG_AW-1:0] REG_FRAME_ROWS  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_COLS  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_WINDOW_SIZE = 2'd2;

  localparam logic [10:0] FRAME_ROWS_RST  = 11'd1024;
  localparam logic [10:0] FRAME_COLS_RST  = 11'd1024;
  localparam logic [3:0]  WINDOW_SIZE_RST = 4'd3;

  // Input kinds carried on tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Control of the column-sum chain
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/bmf_ram.sv @@
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bmf_cell.sv @@
module bmf_cell import bmf_pkg::*; #(
  parameter int W = 12
) (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  // Clear at row start, on a shift take the column sum on d_in, otherwise hold
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      q_r <= '0;
    end else if (ctl.shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

@@ rtl/bmf_div.sv @@
module bmf_div #(
  parameter int NW = 15,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dvs_r, dvs_nxt;
  logic [DW:0]     sh;

  // One quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r, quo_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(NW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = DW'(sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = DW'(sh);
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/box_mean_filter_replicate_border.sv @@
// Box mean filter with replicated border: one item in flight at a time.
// An item that yields no result goes back to idle after the readiness check. An item that
// yields a result reads S column sums at a row start (S = window size) and one otherwise,
// each over S stored rows, then divides serially (dividend 15 bits at the default window of 9).
// The line store's single read port (one pixel per cycle) and the serial divider set the pace.
// Reset (rst_n low, synchronous) restores the register defaults and restarts the frame.
module box_mean_filter_replicate_border import bmf_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // [7:0] pixel_in
  input  logic              in_tuser,   // [0] req_type
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,  // [7:0] pixel_out
  output logic              out_tlast,  // frame_done
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // Line store ring: enough rows for the window above plus the rows the
  // input may run ahead of the output.
  localparam int RING  = 2 * (MAX_WINDOW / 2) + 2;
  localparam int SW    = $clog2(RING);
  localparam int DEPTH = RING * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int PW    = $clog2(MAX_ROWS) + 2;
  localparam int QW    = $clog2(MAX_COLS) + 2;
  localparam int CSW   = $clog2(MAX_WINDOW * 255 + 1);
  localparam int TW    = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int DW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int WIX   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_COLST = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_DIVGO = 3'd5;
  localparam logic [2:0] ST_DIVW  = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  // Configuration registers
  logic [10:0] frame_rows_r, frame_rows_nxt;
  logic [10:0] frame_cols_r, frame_cols_nxt;
  logic [3:0]  window_size_r, window_size_nxt;

  // Frame position
  logic [RIW-1:0] in_row_r, in_row_nxt;
  logic [CIW-1:0] in_col_r, in_col_nxt;
  logic [SW-1:0]  in_slot_r, in_slot_nxt;
  logic [RIW-1:0] out_row_r, out_row_nxt;
  logic [CIW-1:0] out_col_r, out_col_nxt;
  logic [SW-1:0]  out_slot_r, out_slot_nxt;
  logic           complete_r, complete_nxt;

  // Sequencer
  logic [2:0]     state_r, state_nxt;
  logic [3:0]     cols_left_r, cols_left_nxt;
  logic [4:0]     cidx_r, cidx_nxt;
  logic [3:0]     rcnt_r, rcnt_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [CIW-1:0] rcol_r, rcol_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic [CSW-1:0] colsum_r, colsum_nxt;
  logic [TW-1:0]  total_r, total_nxt;

  // Result register
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [PIX_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tlast_r, out_tlast_nxt;

  // Effective (clamped) geometry
  logic [RW-1:0]  rows_c, rows_m1;
  logic [CLW-1:0] cols_c, cols_m1;
  logic [3:0]     size_c, hi, nlo;

  logic [RW:0]    nr_raw;
  logic [CLW:0]   nc_raw;
  logic [RW-1:0]  need_row;
  logic [CLW-1:0] need_col;
  logic           ready;
  logic           last;
  logic           in_acc;
  logic           out_free;

  logic [SW-1:0]  dskip;
  logic [QW-1:0]  cpos;
  logic [PW-1:0]  pos_inc;

  cell_ctl_t      cctl;
  logic [CSW-1:0] cell_q [MAX_WINDOW];
  logic [CSW-1:0] drop;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  logic           div_start, div_done;
  logic [TW-1:0]  div_quo;
  logic [DW-1:0]  div_dvs;

  // Clamp the registers into their working ranges
  always_comb begin
    if (frame_rows_r == '0) begin
      rows_c = RW'(1);
    end else if (frame_rows_r > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(frame_rows_r);
    end
    if (frame_cols_r == '0) begin
      cols_c = CLW'(1);
    end else if (frame_cols_r > MAX_COLS) begin
      cols_c = CLW'(MAX_COLS);
    end else begin
      cols_c = CLW'(frame_cols_r);
    end
    if (window_size_r == '0) begin
      size_c = 4'd1;
    end else if (window_size_r > MAX_WINDOW) begin
      size_c = 4'(MAX_WINDOW);
    end else begin
      size_c = window_size_r;
    end
  end

  assign rows_m1 = rows_c - 1'b1;
  assign cols_m1 = cols_c - 1'b1;
  assign hi      = size_c >> 1;
  assign nlo     = size_c - 4'd1 - hi;

  // An output is ready once the lowest-right pixel of its window has arrived
  assign nr_raw   = (RW+1)'(out_row_r) + (RW+1)'(hi);
  assign nc_raw   = (CLW+1)'(out_col_r) + (CLW+1)'(hi);
  assign need_row = (nr_raw > (RW+1)'(rows_m1)) ? rows_m1 : RW'(nr_raw);
  assign need_col = (nc_raw > (CLW+1)'(cols_m1)) ? cols_m1 : CLW'(nc_raw);
  assign ready    = complete_r || (need_row < RW'(in_row_r)) ||
                    ((need_row == RW'(in_row_r)) && (need_col < CLW'(in_col_r)));
  assign last     = (RW'(out_row_r) == rows_m1) && (CLW'(out_col_r) == cols_m1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Top row of the window is clamped at the frame top: back off at most nlo slots
  assign dskip   = (out_row_r < RIW'(nlo)) ? SW'(out_row_r) : SW'(nlo);
  assign cpos    = QW'(out_col_r) + {{(QW-5){cidx_r[4]}}, cidx_r};
  assign pos_inc = pos_r + 1'b1;

  assign ram_we    = in_acc && (in_tuser == REQ_PIXEL) && !complete_r;
  assign ram_waddr = AW'(in_slot_r) * AW'(MAX_COLS) + AW'(in_col_r);
  assign ram_re    = (state_r == ST_READ) && (rcnt_r != '0);
  assign ram_raddr = AW'(slot_r) * AW'(MAX_COLS) + AW'(rcol_r);

  assign cctl.clr   = (state_r == ST_CHECK) && ready && (out_col_r == '0);
  assign cctl.shift = (state_r == ST_SHIFT);
  assign drop       = cell_q[WIX'(size_c - 4'd1)];

  assign div_start = (state_r == ST_DIVGO);
  assign div_dvs   = DW'(size_c) * DW'(size_c);

  always_comb begin
    frame_rows_nxt  = frame_rows_r;
    frame_cols_nxt  = frame_cols_r;
    window_size_nxt = window_size_r;
    in_row_nxt      = in_row_r;
    in_col_nxt      = in_col_r;
    in_slot_nxt     = in_slot_r;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    out_slot_nxt    = out_slot_r;
    complete_nxt    = complete_r;
    state_nxt       = state_r;
    cols_left_nxt   = cols_left_r;
    cidx_nxt        = cidx_r;
    rcnt_nxt        = rcnt_r;
    pos_nxt         = pos_r;
    slot_nxt        = slot_r;
    rcol_nxt        = rcol_r;
    rd_pend_nxt     = 1'b0;
    colsum_nxt      = colsum_r;
    total_nxt       = total_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;
    out_tlast_nxt   = out_tlast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Store the pixel and advance the raster position
          if (ram_we) begin
            if (CLW'(in_col_r) == cols_m1) begin
              in_col_nxt = '0;
              if (RW'(in_row_r) == rows_m1) begin
                in_row_nxt   = '0;
                in_slot_nxt  = '0;
                complete_nxt = 1'b1;
              end else begin
                in_row_nxt  = in_row_r + 1'b1;
                in_slot_nxt = (in_slot_r == SW'(RING - 1)) ? '0 : in_slot_r + 1'b1;
              end
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!ready) begin
          state_nxt = ST_IDLE;
        end else begin
          // Row start refills the whole chain, otherwise one new column
          if (out_col_r == '0) begin
            total_nxt     = '0;
            cidx_nxt      = 5'd0 - 5'(nlo);
            cols_left_nxt = size_c;
          end else begin
            cidx_nxt      = 5'(hi);
            cols_left_nxt = 4'd1;
          end
          state_nxt = ST_COLST;
        end
      end
      ST_COLST: begin
        colsum_nxt = '0;
        rcnt_nxt   = size_c;
        pos_nxt    = PW'(out_row_r) - PW'(nlo);
        slot_nxt   = (out_slot_r >= dskip) ? out_slot_r - dskip :
                     SW'((SW+1)'(out_slot_r) + (SW+1)'(RING) - (SW+1)'(dskip));
        if (cpos[QW-1]) begin
          rcol_nxt = '0;
        end else if (cpos > QW'(cols_m1)) begin
          rcol_nxt = CIW'(cols_m1);
        end else begin
          rcol_nxt = CIW'(cpos);
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        rd_pend_nxt = ram_re;
        if (ram_re) begin
          rcnt_nxt = rcnt_r - 1'b1;
          pos_nxt  = pos_inc;
          // Move to the next stored row only inside the frame
          if (!pos_inc[PW-1] && (pos_inc != '0) && (pos_inc <= PW'(rows_m1))) begin
            slot_nxt = (slot_r == SW'(RING - 1)) ? '0 : slot_r + 1'b1;
          end
        end
        if (rd_pend_r) begin
          colsum_nxt = colsum_r + CSW'(ram_rdata);
        end
        if ((rcnt_r == '0) && !rd_pend_r) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        total_nxt     = total_r + TW'(colsum_r) - TW'(drop);
        cidx_nxt      = cidx_r + 5'd1;
        cols_left_nxt = cols_left_r - 1'b1;
        state_nxt     = (cols_left_r == 4'd1) ? ST_DIVGO : ST_COLST;
      end
      ST_DIVGO: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold the quotient until the result register frees up
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = PIX_W'(div_quo);
          out_tlast_nxt  = last;
          if (last) begin
            in_row_nxt   = '0;
            in_col_nxt   = '0;
            in_slot_nxt  = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            out_slot_nxt = '0;
            complete_nxt = 1'b0;
          end else if (CLW'(out_col_r) == cols_m1) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + 1'b1;
            out_slot_nxt = (out_slot_r == SW'(RING - 1)) ? '0 : out_slot_r + 1'b1;
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A write to any of the three registers restarts the frame
    if (cfg_we && (cfg_addr == REG_FRAME_ROWS || cfg_addr == REG_FRAME_COLS ||
                   cfg_addr == REG_WINDOW_SIZE)) begin
      unique case (cfg_addr)
        REG_FRAME_ROWS:  frame_rows_nxt  = cfg_wdata;
        REG_FRAME_COLS:  frame_cols_nxt  = cfg_wdata;
        REG_WINDOW_SIZE: window_size_nxt = cfg_wdata[3:0];
        default: begin
        end
      endcase
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_slot_nxt = '0;
      complete_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r  <= FRAME_ROWS_RST;
      frame_cols_r  <= FRAME_COLS_RST;
      window_size_r <= WINDOW_SIZE_RST;
      in_row_r      <= '0;
      in_col_r      <= '0;
      in_slot_r     <= '0;
      out_row_r     <= '0;
      out_col_r     <= '0;
      out_slot_r    <= '0;
      complete_r    <= 1'b0;
      state_r       <= ST_IDLE;
      cols_left_r   <= '0;
      rcnt_r        <= '0;
      slot_r        <= '0;
      rd_pend_r     <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      frame_rows_r  <= frame_rows_nxt;
      frame_cols_r  <= frame_cols_nxt;
      window_size_r <= window_size_nxt;
      in_row_r      <= in_row_nxt;
      in_col_r      <= in_col_nxt;
      in_slot_r     <= in_slot_nxt;
      out_row_r     <= out_row_nxt;
      out_col_r     <= out_col_nxt;
      out_slot_r    <= out_slot_nxt;
      complete_r    <= complete_nxt;
      state_r       <= state_nxt;
      cols_left_r   <= cols_left_nxt;
      rcnt_r        <= rcnt_nxt;
      slot_r        <= slot_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cidx_r      <= cidx_nxt;
    pos_r       <= pos_nxt;
    rcol_r      <= rcol_nxt;
    colsum_r    <= colsum_nxt;
    total_r     <= total_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  bmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Column sums of the current window, newest in cell 0
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_chain
    if (k == 0) begin : g_head
      bmf_cell #(.W(CSW)) u_cell (
        .clk  (clk),
        .ctl  (cctl),
        .d_in (colsum_r),
        .q    (cell_q[k])
      );
    end else begin : g_body
      bmf_cell #(.W(CSW)) u_cell (
        .clk  (clk),
        .ctl  (cctl),
        .d_in (cell_q[k-1]),
        .q    (cell_q[k])
      );
    end
  end

  bmf_div #(
    .NW (TW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_CHECK)
    else $error("accepted item not followed by readiness check");

  a_slots_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    in_slot_r < SW'(RING) && out_slot_r < SW'(RING) && slot_r < SW'(RING))
    else $error("line store slot beyond ring");

  a_shift_has_column: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> cols_left_r != '0)
    else $error("chain shift without pending column");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW)
    else $error("divider finished outside its wait state");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free |=> out_tvalid && state_r == ST_IDLE)
    else $error("result not loaded on emit");

endmodule
